/* rtl/core/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared codes, defaults and the controller-to-datapath command type for the
// positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 5;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_EXT_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_EXT_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_EXT_AT    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // run the captured operation and register the result
  } pls_cmd_t;

endpackage

/* rtl/core/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of up to DEPTH signed 32-bit words with insert and extract
// at the front, the back or a given position.
// ----------------------------------------------------------------------------
//  channel  | handshake          | fields
//  ---------+--------------------+-------------------------------------------
//  input    | start, busy        | in_op, in_value, in_index
//  result   | out_valid (strobe) | out_data, out_status, out_count
//
//  A word is taken when start is high and busy is low; busy is high for the
//  next cycle while the cell array shifts, and the result strobes in the cycle
//  after that. A new word may be taken in the strobe cycle. Synchronous
//  active-low reset empties the list; cell contents are left as they are.
//  The receiver cannot stall: each result is valid for one cycle.
// ----------------------------------------------------------------------------
module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [pls_pkg::OP_W-1:0]           in_op,
  input  logic signed [pls_pkg::DATA_W-1:0]  in_value,
  input  logic [pls_pkg::IDX_W-1:0]          in_index,
  output logic                               out_valid,
  output logic signed [pls_pkg::DATA_W-1:0]  out_data,
  output logic [pls_pkg::STAT_W-1:0]         out_status,
  output logic [pls_pkg::CNT_W-1:0]          out_count
);
  import pls_pkg::*;

  pls_cmd_t cmd;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_value   (in_value),
    .in_index   (in_index),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule

/* rtl/core/pls_ctrl.sv */
// ----------------------------------------------------------------------------
// pls_ctrl
// Two-state sequencer: takes a command word, then runs it in the datapath
// and strobes the result.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output pls_pkg::pls_cmd_t cmd
);
  import pls_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/pls_datapath.sv */
// ----------------------------------------------------------------------------
// pls_datapath
// Shifting cell array with occupancy count. Decodes the captured word,
// checks full/empty/range, shifts the cells and registers the result.
// ----------------------------------------------------------------------------
module pls_datapath #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pls_pkg::pls_cmd_t                  cmd,
  input  logic [pls_pkg::OP_W-1:0]           in_op,
  input  logic signed [pls_pkg::DATA_W-1:0]  in_value,
  input  logic [pls_pkg::IDX_W-1:0]          in_index,
  output logic signed [pls_pkg::DATA_W-1:0]  out_data,
  output logic [pls_pkg::STAT_W-1:0]         out_status,
  output logic [pls_pkg::CNT_W-1:0]          out_count
);
  import pls_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(DEPTH);
  localparam int PW    = (OCC_W > IDX_W) ? OCC_W + 1 : IDX_W + 1;

  logic [OP_W-1:0]          op_r;
  logic [DATA_W-1:0]        value_r;
  logic [IDX_W-1:0]         index_r;
  logic [DATA_W-1:0]        cells_r   [DEPTH];
  logic [DATA_W-1:0]        cells_nxt [DEPTH];
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic [DATA_W-1:0]        data_r, data_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]         count_r;

  logic              is_ins, is_ext, full, empty, ins_ok, ext_ok;
  logic [PW-1:0]     occ_w, idx_w, pos;
  logic [PW-1:0]     occ_ext;

  always_comb begin
    occ_w  = PW'(occ_r);
    idx_w  = PW'(index_r);
    is_ins = (op_r == OP_INS_FRONT) || (op_r == OP_INS_BACK) || (op_r == OP_INS_AT);
    is_ext = (op_r == OP_EXT_FRONT) || (op_r == OP_EXT_BACK) || (op_r == OP_EXT_AT);
    full   = (occ_r == OCC_W'(DEPTH));
    empty  = (occ_r == '0);

    case (op_r)
      OP_INS_FRONT, OP_EXT_FRONT: pos = '0;
      OP_INS_BACK:                pos = occ_w;
      OP_EXT_BACK:                pos = occ_w - PW'(1);
      default:                    pos = idx_w;
    endcase

    ins_ok = is_ins && !full && (pos <= occ_w);
    ext_ok = is_ext && !empty && (pos < occ_w);

    status_nxt = ST_OK;
    if (is_ins && full)                  status_nxt = ST_FULL;
    else if (is_ins && !ins_ok)          status_nxt = ST_RANGE;
    else if (is_ext && empty)            status_nxt = ST_EMPTY;
    else if (is_ext && !ext_ok)          status_nxt = ST_RANGE;

    data_nxt = '0;
    if (ext_ok) data_nxt = cells_r[pos[CW-1:0]];

    occ_nxt = occ_r;
    if (ins_ok)      occ_nxt = occ_r + OCC_W'(1);
    else if (ext_ok) occ_nxt = occ_r - OCC_W'(1);
    occ_ext = PW'(occ_nxt);

    // every cell picks its neighbor, the new word or holds
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (ins_ok) begin
        if (PW'(i) == pos)     cells_nxt[i] = value_r;
        else if (PW'(i) > pos) cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
      end else if (ext_ok) begin
        if (PW'(i) >= pos && i < DEPTH - 1) cells_nxt[i] = cells_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
      index_r <= in_index;
    end
    if (cmd.exec) begin
      cells_r  <= cells_nxt;
      data_r   <= data_nxt;
      status_r <= status_nxt;
      count_r  <= occ_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.exec) begin
      occ_r <= occ_nxt;
    end
  end

  assign out_data   = data_r;
  assign out_status = status_r;
  assign out_count  = count_r;

endmodule
